// ===== design/isrt_pkg.sv =====
// shared types and constants for the insertion sorter
`timescale 1ns / 1ps

package isrt_pkg;

   localparam int ISRT_MAX_ITEMS = 16;
   localparam int ISRT_DATA_W    = 32;

   typedef struct packed {
      logic signed [ISRT_DATA_W-1:0] value;
      logic                          last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [ISRT_DATA_W-1:0] sorted_value;
      logic                          last_out;
      logic                          overflow;
   } rsp_payload_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic                          insert;
      logic                          shift;
      logic signed [ISRT_DATA_W-1:0] value;
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                          valid;
      logic                          gt;
      logic signed [ISRT_DATA_W-1:0] data;
   } cell_link_type;

endpackage

// ===== design/insertion_sorter_top.sv =====
// insertion sorter: a row of cells kept in ascending order, emptied at the end of a run
// storage: each accepted beat is written into the cell registers if the row has room;
//   final beat starts the drain: one result per cycle unless stalled, up to MAX_ITEMS
// throughput: 1 input beat per cycle while filling; input stalls while the row drains
// reset: synchronous, active high; empties the row, clears the drop flag and output valid
`timescale 1ns / 1ps

module insertion_sorter_top #(
   parameter int MAX_ITEMS = isrt_pkg::ISRT_MAX_ITEMS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  isrt_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output isrt_pkg::rsp_payload_type rsp_payload
);
   import isrt_pkg::*;

   localparam logic ST_FILL = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic            state_ff, state_in;
   logic            dropped_ff, dropped_in;
   logic            ovf_ff, ovf_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   cell_cmd_type  cmd;
   cell_link_type links [MAX_ITEMS];
   cell_link_type idle_link;

   logic req_accept;
   logic full;
   logic can_load;

   assign idle_link = '{valid: 1'b0, gt: 1'b0, data: '0};

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
         cell_link_type prev_l, next_l;
         if (gi == 0) begin : g_first
            assign prev_l = idle_link;
         end else begin : g_prev
            assign prev_l = links[gi-1];
         end
         if (gi == MAX_ITEMS - 1) begin : g_end
            assign next_l = idle_link;
         end else begin : g_next
            assign next_l = links[gi+1];
         end
         isrt_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (links[gi])
         );
      end
   endgenerate

   assign full       = links[MAX_ITEMS-1].valid;
   assign req_stall  = (state_ff == ST_EMIT);
   assign req_accept = req_valid && !req_stall;
   assign can_load   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      dropped_in   = dropped_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd.insert   = 1'b0;
      cmd.shift    = 1'b0;
      cmd.value    = req_payload.value;
      unique case (state_ff)
         ST_FILL: begin
            if (req_accept) begin
               cmd.insert = !full;
               if (req_payload.last_in) begin
                  ovf_in     = dropped_ff || full;
                  dropped_in = 1'b0;
                  state_in   = ST_EMIT;
               end else if (full) begin
                  dropped_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            // drain from the low end, one beat per cycle while the output is not stalled
            if (can_load && links[0].valid) begin
               cmd.shift                = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = links[0].data;
               rsp_data_in.last_out     = !links[1].valid;
               rsp_data_in.overflow     = ovf_ff;
               if (!links[1].valid) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         dropped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dropped_ff   <= dropped_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== design/isrt_cell.sv =====
// one storage cell of the sorting row
`timescale 1ns / 1ps

module isrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  isrt_pkg::cell_cmd_type  cmd,
   input  isrt_pkg::cell_link_type prev_link,
   input  isrt_pkg::cell_link_type next_link,
   output isrt_pkg::cell_link_type link
);
   import isrt_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [ISRT_DATA_W-1:0] data_ff, data_in;
   logic                          gt;

   // an empty cell counts as greater than anything, equal values stay put
   assign gt = !valid_ff || (data_ff > cmd.value);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.insert) begin
         if (prev_link.gt) begin
            valid_in = prev_link.valid;
            data_in  = prev_link.data;
         end else if (gt) begin
            valid_in = 1'b1;
            data_in  = cmd.value;
         end
      end else if (cmd.shift) begin
         valid_in = next_link.valid;
         data_in  = next_link.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign link.valid = valid_ff;
   assign link.gt    = gt;
   assign link.data  = data_ff;

endmodule
